@@ hdl/khca_pkg.sv @@
// ----------------------------------------------------------------------------
// khca_pkg
// Shared types and constants for the keyed hit/crit accumulator table.
// ----------------------------------------------------------------------------
package khca_pkg;

  localparam int TABLE_ENTRIES = 64;
  localparam int IDX_W         = $clog2(TABLE_ENTRIES);
  localparam int USED_W        = $clog2(TABLE_ENTRIES + 1);
  localparam int KEY_W         = 32;
  localparam int AMT_W         = 32;
  localparam int SUM_W         = 48;
  localparam int CNT_W         = 32;

  typedef enum logic [1:0] {
    OP_RECORD = 2'd0,
    OP_CLEAR  = 2'd1,
    OP_READ   = 2'd2,
    OP_NOP    = 2'd3
  } op_e_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SCAN,
    ST_UPDATE,
    ST_READ
  } state_t;

  typedef struct packed {
    logic [1:0]       operation;
    logic [KEY_W-1:0] key_id;
    logic [AMT_W-1:0] amount;
    logic             is_crit;
    logic [IDX_W-1:0] read_index;
  } in_item_t;

  typedef struct packed {
    logic [IDX_W-1:0]  entry_index;
    logic              new_entry;
    logic              dropped;
    logic [KEY_W-1:0]  entry_key;
    logic [SUM_W-1:0]  entry_total;
    logic [CNT_W-1:0]  normal_count;
    logic [SUM_W-1:0]  normal_sum;
    logic [CNT_W-1:0]  crit_count;
    logic [SUM_W-1:0]  crit_sum;
    logic [SUM_W-1:0]  grand_total;
    logic [USED_W-1:0] entries_used;
  } out_item_t;

  // One table row as held in the record memory.
  typedef struct packed {
    logic [KEY_W-1:0] key;
    logic [SUM_W-1:0] total;
    logic [CNT_W-1:0] ncnt;
    logic [SUM_W-1:0] nsum;
    logic [CNT_W-1:0] ccnt;
    logic [SUM_W-1:0] csum;
  } entry_t;

  // Controller to datapath.
  typedef struct packed {
    logic accept;    // latch the incoming item, restart the scan pointer
    logic fin_now;   // finish clear, no-op or out-of-range read at once
    logic scan;      // one step of the key search
    logic update;    // read-modify-write of the found or appended entry
    logic read_out;  // return the entry fetched for a read
  } ctl_cmd_t;

  // Datapath to controller.
  typedef struct packed {
    op_e_t op;         // operation of the incoming item
    logic  read_ok;    // incoming read index names a valid entry
    logic  hit;        // key matched the entry under compare
    logic  scan_done;  // every valid entry compared without a match
  } ctl_sts_t;

endpackage

@@ hdl/keyed_hit_crit_accumulator.sv @@
// ----------------------------------------------------------------------------
// keyed_hit_crit_accumulator
// Table of per-key hit/crit totals, searched in insertion order.
// ----------------------------------------------------------------------------
//
//   Channel   Signals              Transfer condition
//   --------  -------------------  ---------------------------------------
//   item in   start, busy, item    rising edge with start high, busy low
//   result    done, result         rising edge ending the cycle done is high
//
// From the transfer to the done strobe, a record scans the valid entries for
// its key, then updates the found entry or appends a new one (or drops the
// item when the table is full); a read of a valid entry fetches and returns
// it; clear, no-op and an invalid read finish at once.
// The key search steps the single read port of the record memory one entry
// a cycle, with one trailing compare and, on a miss, a final step to see
// the end of the table; the write port closes each record that is not dropped.
// A new item may transfer while the previous result strobes.
// Reset clears the entry count and grand total; the record memory needs no
// clearing pass since only entries below the count are ever used.
// The result port cannot be stalled: each result shows for one cycle.
// ----------------------------------------------------------------------------
module keyed_hit_crit_accumulator
  import khca_pkg::*;
(
  input  logic      clk,
  input  logic      rst,
  input  logic      start,
  output logic      busy,
  input  in_item_t  item,
  output logic      done,
  output out_item_t result
);

  ctl_cmd_t cmd;
  ctl_sts_t sts;

  // Sequence each item: accept, search, update or read, finish.
  khca_ctrl u_ctrl (
    .clk   (clk),
    .rst   (rst),
    .start (start),
    .sts   (sts),
    .cmd   (cmd),
    .busy  (busy)
  );

  // Hold the table, totals and the registered result.
  khca_dpath u_dpath (
    .clk     (clk),
    .rst     (rst),
    .in_item (item),
    .cmd     (cmd),
    .sts     (sts),
    .done    (done),
    .result  (result)
  );

endmodule

@@ hdl/khca_ctrl.sv @@
// ----------------------------------------------------------------------------
// khca_ctrl
// Sequencer for accept, key search, entry update and entry read.
// ----------------------------------------------------------------------------
module khca_ctrl
  import khca_pkg::*;
(
  input  logic     clk,
  input  logic     rst,
  input  logic     start,
  input  ctl_sts_t sts,
  output ctl_cmd_t cmd,
  output logic     busy
);

  state_t state, state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    cmd        = '0;
    busy       = 1'b1;
    unique case (state)
      ST_IDLE: begin
        busy = 1'b0;
        if (start) begin
          cmd.accept = 1'b1;
          unique case (sts.op)
            OP_RECORD: state_next = ST_SCAN;
            OP_READ: begin
              if (sts.read_ok) begin
                state_next = ST_READ;
              end else begin
                cmd.fin_now = 1'b1;
              end
            end
            default: cmd.fin_now = 1'b1;
          endcase
        end
      end
      ST_SCAN: begin
        cmd.scan = 1'b1;
        if (sts.hit || sts.scan_done) begin
          state_next = ST_UPDATE;
        end
      end
      ST_UPDATE: begin
        cmd.update = 1'b1;
        state_next = ST_IDLE;
      end
      ST_READ: begin
        cmd.read_out = 1'b1;
        state_next   = ST_IDLE;
      end
      default: state_next = ST_IDLE;
    endcase
  end

endmodule

@@ hdl/khca_dpath.sv @@
// ----------------------------------------------------------------------------
// khca_dpath
// Record memory, scan pointer, saturating update and result register.
// ----------------------------------------------------------------------------
module khca_dpath
  import khca_pkg::*;
(
  input  logic      clk,
  input  logic      rst,
  input  in_item_t  in_item,
  input  ctl_cmd_t  cmd,
  output ctl_sts_t  sts,
  output logic      done,
  output out_item_t result
);

  function automatic logic [SUM_W-1:0] sat_add(input logic [SUM_W-1:0] a,
                                               input logic [AMT_W-1:0] b);
    logic [SUM_W:0] s;
    s = {1'b0, a} + (SUM_W+1)'(b);
    return s[SUM_W] ? {SUM_W{1'b1}} : s[SUM_W-1:0];
  endfunction

  function automatic logic [CNT_W-1:0] sat_inc(input logic [CNT_W-1:0] c);
    return (&c) ? c : c + CNT_W'(1);
  endfunction

  entry_t mem [TABLE_ENTRIES];
  entry_t rdata;

  in_item_t          item;
  logic [USED_W-1:0] used;
  logic [SUM_W-1:0]  overall;
  logic [USED_W-1:0] ptr;
  logic              pend;
  logic [IDX_W-1:0]  cmp_idx;
  logic [IDX_W-1:0]  tgt_idx;
  logic              found;
  out_item_t         res_next;

  logic              full;
  logic              drop;
  logic              issue;
  logic              rd_en;
  logic              wr_en;
  logic [IDX_W-1:0]  raddr;
  entry_t            base;
  entry_t            upd;
  logic [SUM_W-1:0]  overall_add;
  logic [USED_W-1:0] used_upd;

  // Status
  assign sts.op        = op_e_t'(in_item.operation);
  assign sts.read_ok   = USED_W'(in_item.read_index) < used;
  assign sts.hit       = pend && (rdata.key == item.key_id);
  assign sts.scan_done = !pend && (ptr >= used);

  assign issue = cmd.scan && !sts.hit && (ptr < used);
  assign rd_en = cmd.accept || issue;
  assign raddr = cmd.accept ? IDX_W'(in_item.read_index) : ptr[IDX_W-1:0];
  assign full  = (used == USED_W'(TABLE_ENTRIES));
  assign drop  = !found && full;
  assign wr_en = cmd.update && !drop;

  always_ff @(posedge clk) begin
    if (rd_en) begin
      rdata <= mem[raddr];
    end
    if (wr_en) begin
      mem[tgt_idx] <= upd;
    end
  end

  always_comb begin
    base     = found ? rdata : '0;
    base.key = item.key_id;
    upd      = base;
    upd.total = sat_add(base.total, item.amount);
    if (item.is_crit) begin
      upd.ccnt = sat_inc(base.ccnt);
      upd.csum = sat_add(base.csum, item.amount);
    end else begin
      upd.ncnt = sat_inc(base.ncnt);
      upd.nsum = sat_add(base.nsum, item.amount);
    end
    overall_add = sat_add(overall, item.amount);
    used_upd    = (found || full) ? used : used + USED_W'(1);
  end

  always_comb begin
    res_next = '0;
    if (cmd.update) begin
      res_next.grand_total  = overall_add;
      res_next.entries_used = used_upd;
      if (drop) begin
        res_next.dropped = 1'b1;
      end else begin
        res_next.entry_index  = tgt_idx;
        res_next.new_entry    = !found;
        res_next.entry_key    = upd.key;
        res_next.entry_total  = upd.total;
        res_next.normal_count = upd.ncnt;
        res_next.normal_sum   = upd.nsum;
        res_next.crit_count   = upd.ccnt;
        res_next.crit_sum     = upd.csum;
      end
    end else if (cmd.read_out) begin
      res_next.entry_index  = item.read_index;
      res_next.entry_key    = rdata.key;
      res_next.entry_total  = rdata.total;
      res_next.normal_count = rdata.ncnt;
      res_next.normal_sum   = rdata.nsum;
      res_next.crit_count   = rdata.ccnt;
      res_next.crit_sum     = rdata.csum;
      res_next.grand_total  = overall;
      res_next.entries_used = used;
    end else begin
      case (sts.op)
        OP_CLEAR: res_next = '0;
        OP_READ: begin
          res_next.entry_index  = in_item.read_index;
          res_next.dropped      = 1'b1;
          res_next.grand_total  = overall;
          res_next.entries_used = used;
        end
        default: begin
          res_next.grand_total  = overall;
          res_next.entries_used = used;
        end
      endcase
    end
  end

  // Control state
  always_ff @(posedge clk) begin
    if (rst) begin
      used    <= '0;
      overall <= '0;
      ptr     <= '0;
      pend    <= 1'b0;
      found   <= 1'b0;
      done    <= 1'b0;
    end else begin
      done <= cmd.fin_now || cmd.update || cmd.read_out;
      if (cmd.accept) begin
        ptr  <= '0;
        pend <= 1'b0;
      end else if (cmd.scan) begin
        pend <= issue;
        if (issue) begin
          ptr <= ptr + USED_W'(1);
        end
        if (sts.hit || sts.scan_done) begin
          found <= sts.hit;
        end
      end
      if (cmd.update) begin
        overall <= overall_add;
        used    <= used_upd;
      end
      if (cmd.fin_now && sts.op == OP_CLEAR) begin
        overall <= '0;
        used    <= '0;
      end
    end
  end

  // Payload
  always_ff @(posedge clk) begin
    if (cmd.accept) begin
      item <= in_item;
    end
    if (issue) begin
      cmp_idx <= ptr[IDX_W-1:0];
    end
    if (cmd.scan && (sts.hit || sts.scan_done)) begin
      tgt_idx <= sts.hit ? cmp_idx : used[IDX_W-1:0];
    end
    if (cmd.fin_now || cmd.update || cmd.read_out) begin
      result <= res_next;
    end
  end

  a_used_bound: assert property (@(posedge clk) disable iff (rst)
    used <= USED_W'(TABLE_ENTRIES))
    else $error("entry count above table size");

  a_cmp_valid: assert property (@(posedge clk) disable iff (rst)
    (cmd.scan && pend) |-> (USED_W'(cmp_idx) < used))
    else $error("compare on an entry beyond the valid range");

  a_update_done: assert property (@(posedge clk) disable iff (rst)
    cmd.update |=> done)
    else $error("update without result strobe");

  a_append_grows: assert property (@(posedge clk) disable iff (rst)
    (cmd.update && !found && !full) |=> (used == $past(used) + USED_W'(1)))
    else $error("append did not advance the entry count");

  a_total_monotonic: assert property (@(posedge clk) disable iff (rst)
    !(cmd.fin_now && sts.op == OP_CLEAR) |=> (overall >= $past(overall)))
    else $error("grand total fell without a clear");

endmodule
